[hw/rtl/assert_macros.svh]
// Assertion macros used by the checker file of the speed profile block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is high
`define SRS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset
`define SRS_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/srs_pkg.sv]
// Shared types, constants and helper functions of the trapezoid speed profile block.
package srs_pkg;

   // Position and speed widths
   localparam int POS_W   = 24;
   localparam int POS1_W  = POS_W + 1;
   localparam int R_W     = 15;
   localparam int SPD_W   = 16;
   localparam int QUOT_W  = 17;
   localparam int PROD_W  = POS_W + SPD_W;
   localparam int SUM_W   = SPD_W + 3;

   // Residue-by-5 folding (16 = 1 mod 5, so nibbles add up)
   localparam int NIB_N   = (POS_W + 3) / 4;
   localparam int PAD_W   = NIB_N * 4;
   localparam int NSUM_W  = $clog2(NIB_N * 15 + 1);
   localparam int FOLD_W  = 5;
   localparam int MOD_W   = 3;

   // Pipeline: two decode stages, one cell per quotient bit, output register
   localparam int PIPE_DEPTH = QUOT_W + 3;
   localparam int CNT_W      = $clog2(PIPE_DEPTH + 1);

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_RAMP_ENABLE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RAMP_LENGTH = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_SPEED   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_START_SPEED = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DWELL_SPEED = 3'd4;

   // Register reset values
   localparam logic             RST_RAMP_ENABLE = 1'b1;
   localparam logic [R_W-1:0]   RST_RAMP_LENGTH = 15'd100;
   localparam logic [SPD_W-1:0] RST_MAX_SPEED   = 16'd1000;
   localparam logic [SPD_W-1:0] RST_START_SPEED = 16'd100;
   localparam logic [SPD_W-1:0] RST_DWELL_SPEED = 16'd100;

   typedef struct packed {
      logic             enable;
      logic [R_W-1:0]   ramp_length;
      logic [SPD_W-1:0] max_speed;
      logic [SPD_W-1:0] start_speed;
      logic [SPD_W-1:0] dwell_speed;
   } cfg_type;

   // Item as it travels down the divider chain
   typedef struct packed {
      logic              upd;
      logic              dwell;
      logic              neg;
      logic              ovf;
      logic [R_W-1:0]    rem;
      logic [QUOT_W-1:0] work;
   } cell_data_type;

   // Speed used as at least 1
   function automatic logic [SPD_W-1:0] eff_speed(input logic [SPD_W-1:0] v);
      eff_speed = (v == '0) ? SPD_W'(1) : v;
   endfunction

   // Ramp length used as at least 1
   function automatic logic [R_W-1:0] eff_ramp_len(input logic [R_W-1:0] v);
      eff_ramp_len = (v == '0) ? R_W'(1) : v;
   endfunction

   // Sum the nibbles of a position; the sum keeps the residue mod 5
   function automatic logic [NSUM_W-1:0] nibble_sum(input logic [POS_W-1:0] v);
      logic [PAD_W-1:0]  pad;
      logic [NSUM_W-1:0] acc;
      pad = PAD_W'(v);
      acc = '0;
      for (int k = 0; k < NIB_N; k++) begin
         acc = acc + NSUM_W'(pad[4*k +: 4]);
      end
      nibble_sum = acc;
   endfunction

   // Reduce a nibble sum to its residue mod 5
   function automatic logic [MOD_W-1:0] mod5_finish(input logic [NSUM_W-1:0] v);
      logic [FOLD_W-1:0] f;
      f = FOLD_W'(v[3:0]) + FOLD_W'(v[NSUM_W-1:4]);
      for (int k = 0; k < 4; k++) begin
         if (f >= FOLD_W'(5)) begin
            f = f - FOLD_W'(5);
         end
      end
      mod5_finish = f[MOD_W-1:0];
   endfunction

endpackage

[hw/rtl/srs_if.sv]
// Request and response channel interfaces of the speed profile block.
interface srs_req_if;
   import srs_pkg::*;
   logic             valid;
   logic             ready;
   logic [POS_W-1:0] move_length;
   logic [POS_W-1:0] step_index;

   modport source (output valid, output move_length, output step_index, input ready);
   modport sink (input valid, input move_length, input step_index, output ready);
endinterface

interface srs_rsp_if;
   import srs_pkg::*;
   logic             valid;
   logic             ready;
   logic             speed_update;
   logic [SPD_W-1:0] speed;

   modport source (output valid, output speed_update, output speed, input ready);
   modport sink (input valid, input speed_update, input speed, output ready);
endinterface

[hw/rtl/srs_div_cell.sv]
// One restoring-division cell: produces one quotient bit and hands on the remainder.
module srs_div_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  srs_pkg::cell_data_type  in_data,
   output logic                    out_valid,
   input  logic                    out_ready,
   output srs_pkg::cell_data_type  out_data,
   input  logic [srs_pkg::R_W-1:0] divisor
);
   import srs_pkg::*;

   logic          valid_ff;
   logic          valid_in;
   cell_data_type data_ff;
   cell_data_type data_in;
   logic [R_W:0]  shifted;
   logic          ge;

   // Advance when empty or when the neighbor takes the current item
   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   // Shift in the next dividend bit, subtract the divisor when it fits
   always_comb begin
      shifted = {in_data.rem, in_data.work[QUOT_W-1]};
      ge      = shifted >= {1'b0, divisor};
      data_in = in_data;
      if (ge) begin
         data_in.rem = R_W'(shifted - {1'b0, divisor});
      end else begin
         data_in.rem = shifted[R_W-1:0];
      end
      data_in.work = {in_data.work[QUOT_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

[hw/rtl/srs_front.sv]
// Decode stages: region and residue checks, then the slope product for the divider.
module srs_front (
   input  logic                   clock,
   input  logic                   reset,
   input  srs_pkg::cfg_type       cfg,
   srs_req_if.sink                req_ch,
   output logic                   out_valid,
   input  logic                   out_ready,
   output srs_pkg::cell_data_type out_data
);
   import srs_pkg::*;

   logic [R_W-1:0]    r_eff;
   logic [POS_W-1:0]  r_pos;
   logic [POS_W-1:0]  len;
   logic [POS_W-1:0]  idx;
   logic              short_c;
   logic              rise_c;
   logic              fall_c;
   logic              len_ge;
   logic [POS_W-1:0]  nmag_c;
   logic              negn_c;

   logic              f1_valid_ff;
   logic              f1_ready;
   logic              short_ff;
   logic              idx_zero_ff;
   logic              rise_ff;
   logic              fall_ff;
   logic [NSUM_W-1:0] nsum_ff;
   logic [POS_W-1:0]  nmag_ff;
   logic              negn_ff;

   logic [SPD_W-1:0]  top_s;
   logic [SPD_W-1:0]  low_s;
   logic              dneg;
   logic [SPD_W-1:0]  dmag;
   logic [MOD_W-1:0]  mod_c;
   logic              upd_c;
   logic [PROD_W-1:0] prod_c;

   logic              f2_valid_ff;
   logic              f2_ready;
   logic              upd_ff;
   logic              dwell_ff;
   logic              neg_ff;
   logic [PROD_W-1:0] prod_ff;

   // Classify the step against the ramp regions
   always_comb begin
      r_eff   = eff_ramp_len(cfg.ramp_length);
      r_pos   = POS_W'(r_eff);
      len     = req_ch.move_length;
      idx     = req_ch.step_index;
      short_c = POS1_W'(len) < {r_pos, 1'b0};
      rise_c  = idx <= r_pos;
      fall_c  = (POS1_W'(idx) + POS1_W'(r_pos)) >= POS1_W'(len);
      len_ge  = len >= idx;
      if (rise_c) begin
         nmag_c = idx;
      end else if (len_ge) begin
         nmag_c = len - idx;
      end else begin
         nmag_c = idx - len;
      end
      negn_c = !rise_c && !len_ge;
   end

   assign f1_ready     = !f1_valid_ff || f2_ready;
   assign req_ch.ready = f1_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
      end else if (f1_ready) begin
         f1_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (f1_ready && req_ch.valid) begin
         short_ff    <= short_c;
         idx_zero_ff <= (idx == '0);
         rise_ff     <= rise_c;
         fall_ff     <= fall_c;
         nsum_ff     <= nibble_sum(idx);
         nmag_ff     <= nmag_c;
         negn_ff     <= negn_c;
      end
   end

   // Decide the update and form |slope| times the step distance
   always_comb begin
      top_s  = eff_speed(cfg.max_speed);
      low_s  = eff_speed(cfg.start_speed);
      dneg   = top_s < low_s;
      dmag   = dneg ? (low_s - top_s) : (top_s - low_s);
      mod_c  = mod5_finish(nsum_ff);
      upd_c  = cfg.enable &&
               (short_ff ? idx_zero_ff : ((mod_c == '0) && (rise_ff || fall_ff)));
      prod_c = PROD_W'(dmag) * PROD_W'(nmag_ff);
   end

   assign f2_ready = !f2_valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         f2_valid_ff <= 1'b0;
      end else if (f2_ready) begin
         f2_valid_ff <= f1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (f2_ready && f1_valid_ff) begin
         upd_ff   <= upd_c;
         dwell_ff <= short_ff;
         neg_ff   <= negn_ff ^ dneg;
         prod_ff  <= prod_c;
      end
   end

   // Seed the divider: high product bits are the first remainder
   always_comb begin
      out_data.upd   = upd_ff;
      out_data.dwell = dwell_ff;
      out_data.neg   = neg_ff;
      out_data.ovf   = prod_ff[PROD_W-1:QUOT_W] >= (PROD_W - QUOT_W)'(r_eff);
      out_data.rem   = prod_ff[QUOT_W +: R_W];
      out_data.work  = prod_ff[QUOT_W-1:0];
   end

   assign out_valid = f2_valid_ff;

endmodule

[hw/rtl/stepper_trapezoid_ramp_speed.sv]
// Path: a request passes 2 decode stages, 17 divider cells and 1 output register
// on the way to its response, and is held up only while the response is stalled.
// Throughput: one request per cycle unless stalled; one quotient bit per cell.
// Stages fill gaps on their own, so requests are taken while a response waits.
// Reset: synchronous, active high; clears all valid bits and loads the register
// defaults (ramping on, ramp length 100, top 1000, start 100, dwell 100).
module stepper_trapezoid_ramp_speed (
   input  logic                           clock,
   input  logic                           reset,
   srs_req_if.sink                        req_ch,
   srs_rsp_if.source                      rsp_ch,
   input  logic                           csr_write_en,
   input  logic [srs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [srs_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import srs_pkg::*;

   cfg_type          cfg_ff;
   cfg_type          cfg_in;
   logic [R_W-1:0]   r_eff;
   logic [SPD_W-1:0] low_s;

   logic          cell_valid [0:QUOT_W];
   logic          cell_ready [0:QUOT_W];
   cell_data_type cell_data  [0:QUOT_W];

   cell_data_type    last;
   logic [SUM_W-1:0] q_ext;
   logic [SUM_W-1:0] low_ext;
   logic [SUM_W-1:0] sum;
   logic [SPD_W-1:0] ramp_spd;
   logic [SPD_W-1:0] speed_in;
   logic             out_ready;
   logic             rsp_valid_ff;
   logic             rsp_upd_ff;
   logic [SPD_W-1:0] rsp_speed_ff;

   // Configuration register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_RAMP_ENABLE: cfg_in.enable      = csr_wdata[0];
            CSR_RAMP_LENGTH: cfg_in.ramp_length = csr_wdata[R_W-1:0];
            CSR_MAX_SPEED:   cfg_in.max_speed   = csr_wdata[SPD_W-1:0];
            CSR_START_SPEED: cfg_in.start_speed = csr_wdata[SPD_W-1:0];
            CSR_DWELL_SPEED: cfg_in.dwell_speed = csr_wdata[SPD_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable      <= RST_RAMP_ENABLE;
         cfg_ff.ramp_length <= RST_RAMP_LENGTH;
         cfg_ff.max_speed   <= RST_MAX_SPEED;
         cfg_ff.start_speed <= RST_START_SPEED;
         cfg_ff.dwell_speed <= RST_DWELL_SPEED;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign r_eff = eff_ramp_len(cfg_ff.ramp_length);
   assign low_s = eff_speed(cfg_ff.start_speed);

   // Decode stages
   srs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_ch    (req_ch),
      .out_valid (cell_valid[0]),
      .out_ready (cell_ready[0]),
      .out_data  (cell_data[0])
   );

   // Divider chain, one quotient bit per cell
   for (genvar k = 0; k < QUOT_W; k++) begin : g_cell
      srs_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (cell_valid[k]),
         .in_ready  (cell_ready[k]),
         .in_data   (cell_data[k]),
         .out_valid (cell_valid[k+1]),
         .out_ready (cell_ready[k+1]),
         .out_data  (cell_data[k+1]),
         .divisor   (r_eff)
      );
   end

   // Apply the signed quotient to the start speed and saturate
   always_comb begin
      last    = cell_data[QUOT_W];
      q_ext   = SUM_W'(last.work);
      low_ext = SUM_W'(low_s);
      sum     = last.neg ? (low_ext - q_ext) : (low_ext + q_ext);
      if (last.ovf) begin
         ramp_spd = last.neg ? SPD_W'(1) : '1;
      end else if (sum[SUM_W-1] || (sum == '0)) begin
         ramp_spd = SPD_W'(1);
      end else if (|sum[SUM_W-2:SPD_W]) begin
         ramp_spd = '1;
      end else begin
         ramp_spd = sum[SPD_W-1:0];
      end
      if (!last.upd) begin
         speed_in = '0;
      end else if (last.dwell) begin
         speed_in = cfg_ff.dwell_speed;
      end else begin
         speed_in = ramp_spd;
      end
   end

   // Output register; hold while the response is stalled
   assign out_ready          = !rsp_valid_ff || rsp_ch.ready;
   assign cell_ready[QUOT_W] = out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= cell_valid[QUOT_W];
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && cell_valid[QUOT_W]) begin
         rsp_upd_ff   <= last.upd;
         rsp_speed_ff <= speed_in;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.speed_update = rsp_upd_ff;
   assign rsp_ch.speed        = rsp_speed_ff;

endmodule

[hw/rtl/srs_checker.sv]
// Port-level checker for the speed profile block, bound to its top level.
`include "assert_macros.svh"

module srs_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic                       rsp_speed_update,
   input logic [srs_pkg::SPD_W-1:0]  rsp_speed
);
   import srs_pkg::*;

   logic [CNT_W-1:0] occ_ff;
   logic [CNT_W-1:0] occ_in;

   // Track requests accepted but not yet answered
   always_comb begin
      occ_in = occ_ff;
      if (req_valid && req_ready) begin
         occ_in = occ_in + CNT_W'(1);
      end
      if (rsp_valid && rsp_ready) begin
         occ_in = occ_in - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   `SRS_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid,
               "response dropped while stalled")
   `SRS_ASSERT(a_no_update_zero, clock, reset,
               rsp_valid && !rsp_speed_update |-> rsp_speed == '0,
               "speed nonzero without update")
   `SRS_ASSERT(a_rsp_has_req, clock, reset, rsp_valid |-> occ_ff != '0,
               "response without pending request")
   `SRS_ASSERT(a_occ_bound, clock, reset, occ_ff <= CNT_W'(PIPE_DEPTH),
               "more requests in flight than stages")
   `SRS_ASSERT_NR(a_reset_clear, clock, $past(reset) |-> !rsp_valid,
                  "response valid right after reset")

endmodule

bind stepper_trapezoid_ramp_speed srs_checker u_srs_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_ch.valid),
   .req_ready        (req_ch.ready),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_speed_update (rsp_ch.speed_update),
   .rsp_speed        (rsp_ch.speed)
);

[tb/tb_stepper_trapezoid_ramp_speed.sv]
// Self-checking testbench for the trapezoid speed profile block over its request/response channels.
`timescale 1ns / 1ps

module tb_stepper_trapezoid_ramp_speed;
   import srs_pkg::*;

   localparam longint POS_MAX        = (longint'(1) << POS_W) - 1;
   localparam longint SPEED_CEIL     = (longint'(1) << SPD_W) - 1;
   localparam int     WATCHDOG_LIMIT = 3000;
   localparam int     DRAIN_CYCLES   = 2 * PIPE_DEPTH;
   localparam int     HOLD_AFTER     = 1000;
   localparam int     HOLD_CYCLES    = 300;
   localparam int     PHASE_ITEMS    = 190;

   // One predicted response, with the request that caused it for reporting
   typedef struct {
      logic             upd;
      logic [SPD_W-1:0] spd;
      logic [POS_W-1:0] len;
      logic [POS_W-1:0] idx;
   } speed_due_type;

   // Register mirror, speed predictor and queue of responses still owed
   class speed_scoreboard_type;
      cfg_type       cfg;
      speed_due_type speed_due[$];
      int            errors;
      int            checked;
      int            updates;

      function new();
         cfg.enable      = RST_RAMP_ENABLE;
         cfg.ramp_length = RST_RAMP_LENGTH;
         cfg.max_speed   = RST_MAX_SPEED;
         cfg.start_speed = RST_START_SPEED;
         cfg.dwell_speed = RST_DWELL_SPEED;
         errors  = 0;
         checked = 0;
         updates = 0;
      endfunction

      function void set_register(input logic [CSR_IDX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] value);
         case (index)
            CSR_RAMP_ENABLE: cfg.enable      = value[0];
            CSR_RAMP_LENGTH: cfg.ramp_length = value[R_W-1:0];
            CSR_MAX_SPEED:   cfg.max_speed   = value[SPD_W-1:0];
            CSR_START_SPEED: cfg.start_speed = value[SPD_W-1:0];
            CSR_DWELL_SPEED: cfg.dwell_speed = value[SPD_W-1:0];
            default: ;
         endcase
      endfunction

      // Work out the trapezoid speed for one step of a move
      function void ramp_speed_of(input logic [POS_W-1:0] len_in,
                                  input logic [POS_W-1:0] idx_in,
                                  output speed_due_type due);
         longint len, idx, r, top, low, diff, v;
         len  = len_in;
         idx  = idx_in;
         r    = (cfg.ramp_length == 0) ? 1 : cfg.ramp_length;
         top  = (cfg.max_speed == 0) ? 1 : cfg.max_speed;
         low  = (cfg.start_speed == 0) ? 1 : cfg.start_speed;
         diff = top - low;
         v    = 0;
         due.len = len_in;
         due.idx = idx_in;
         due.upd = 1'b0;
         due.spd = '0;
         if (cfg.enable) begin
            if (len < 2 * r) begin
               // short move: dwell speed once, at the first step
               if (idx == 0) begin
                  due.upd = 1'b1;
                  due.spd = cfg.dwell_speed;
               end
            end else if (idx % 5 == 0) begin
               // rise wins where rise and fall overlap
               if (idx <= r) begin
                  due.upd = 1'b1;
                  v = low + (diff * idx) / r;
               end else if (idx >= len - r) begin
                  due.upd = 1'b1;
                  v = low + (diff * (len - idx)) / r;
               end
               if (due.upd) begin
                  if (v < 1) v = 1;
                  else if (v > SPEED_CEIL) v = SPEED_CEIL;
                  due.spd = v[SPD_W-1:0];
               end
            end
         end
      endfunction

      function void note_request(input logic [POS_W-1:0] len, input logic [POS_W-1:0] idx);
         speed_due_type due;
         ramp_speed_of(len, idx, due);
         speed_due.push_back(due);
      endfunction

      function void check_response(input logic upd, input logic [SPD_W-1:0] spd);
         speed_due_type due;
         checked++;
         if (upd === 1'b1) updates++;
         if (speed_due.size() == 0) begin
            errors++;
            $display("%0t: response with no request pending: update %0b speed %0d",
                     $time, upd, spd);
            return;
         end
         due = speed_due.pop_front();
         if (upd !== due.upd) begin
            errors++;
            $display("%0t: speed_update mismatch (length %0d, index %0d): expected %0b, actual %0b",
                     $time, due.len, due.idx, due.upd, upd);
         end
         if (spd !== due.spd) begin
            errors++;
            $display("%0t: speed mismatch (length %0d, index %0d): expected %0d, actual %0d",
                     $time, due.len, due.idx, due.spd, spd);
         end
      endfunction

      function int pending();
         return speed_due.size();
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_write_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   srs_req_if req_if ();
   srs_rsp_if rsp_if ();

   speed_scoreboard_type board;
   int send_idle_pct  = 12;
   int rsp_idle_pct   = 73;
   int requests_sent  = 0;
   int settings_run   = 0;
   int hold_left      = 0;
   bit hold_done      = 1'b0;
   int idle_cycles    = 0;

   stepper_trapezoid_ramp_speed u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_ch       (req_if),
      .rsp_ch       (rsp_if),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #6 clock = ~clock;

   // Offer one request after a random gap and hold it until taken
   task automatic send_request(input logic [POS_W-1:0] len, input logic [POS_W-1:0] idx);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.move_length <= len;
      req_if.step_index  <= idx;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      board.note_request(len, idx);
      requests_sent++;
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      csr_write_en <= 1'b1;
      csr_index    <= index;
      csr_wdata    <= value;
      @(posedge clock);
      board.set_register(index, value);
   endtask

   task automatic wait_drained();
      while (board.pending() != 0) @(posedge clock);
   endtask

   // Random request shaped by the ramp length now in force
   function automatic void pick_request(output logic [POS_W-1:0] len_o,
                                        output logic [POS_W-1:0] idx_o);
      longint      r, len, idx;
      int unsigned kind;
      r    = (board.cfg.ramp_length == 0) ? 1 : board.cfg.ramp_length;
      kind = $urandom_range(99);
      // long move: mostly just past twice the ramp, now and then far longer
      if ($urandom_range(3) == 0) len = $urandom_range(POS_MAX, 2 * r);
      else len = 2 * r + $urandom_range(3 * r + 20);
      if (kind < 40) begin
         // rise, mostly on multiples of five
         idx = (kind < 34) ? 5 * $urandom_range(r / 5) : $urandom_range(r);
      end else if (kind < 65) begin
         // fall, rounded down to a multiple of five
         idx = len - $urandom_range(r);
         idx = idx - idx % 5;
      end else if (kind < 72) begin
         // past the end of the move
         idx = len - len % 5 + 5 * $urandom_range(2000, 1);
         if (idx > POS_MAX) idx = POS_MAX;
      end else if (kind < 82) begin
         // short move
         len = $urandom_range(2 * r - 1);
         idx = ($urandom_range(1) == 0) ? 0 : 5 * $urandom_range(r);
      end else if (kind < 90) begin
         idx = $urandom_range(len);
      end else begin
         len = $urandom_range(POS_MAX);
         idx = $urandom_range(POS_MAX);
      end
      len_o = len[POS_W-1:0];
      idx_o = idx[POS_W-1:0];
   endfunction

   // Load one register setting, then run random requests under it
   task automatic run_phase(input logic en, input logic [R_W-1:0] rlen,
                            input logic [SPD_W-1:0] top, input logic [SPD_W-1:0] base,
                            input logic [SPD_W-1:0] dwell, input int s_pct, input int r_pct);
      logic [POS_W-1:0] len, idx;
      send_idle_pct = s_pct;
      rsp_idle_pct  = r_pct;
      write_reg(CSR_RAMP_ENABLE, CSR_DATA_W'(en));
      write_reg(CSR_RAMP_LENGTH, CSR_DATA_W'(rlen));
      write_reg(CSR_MAX_SPEED, top);
      write_reg(CSR_START_SPEED, base);
      write_reg(CSR_DWELL_SPEED, dwell);
      csr_write_en <= 1'b0;
      settings_run++;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
         pick_request(len, idx);
         send_request(len, idx);
      end
      req_if.valid <= 1'b0;
      wait_drained();
   endtask

   // Take responses and check them; stall at random, once for a long stretch
   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready)
            board.check_response(rsp_if.speed_update, rsp_if.speed);
         if (!hold_done && requests_sent >= HOLD_AFTER) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= !reset && ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   // Abort when neither channel moves for too long
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("tb_stepper_trapezoid_ramp_speed failed");
         $finish;
      end
   end

   initial begin
      board              = new();
      reset              <= 1'b1;
      csr_write_en       <= 1'b0;
      csr_index          <= CSR_RAMP_ENABLE;
      csr_wdata          <= '0;
      req_if.valid       <= 1'b0;
      req_if.move_length <= '0;
      req_if.step_index  <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed requests against the reset settings (ramp 100, 100 to 1000, dwell 100)
      settings_run++;
      send_request(24'd0, 24'd0);               // short move, first step
      send_request(24'd199, 24'd0);             // just short of twice the ramp
      send_request(24'd199, 24'd5);             // short move, later step
      send_request(24'd200, 24'd0);             // exactly twice the ramp
      send_request(24'd200, 24'd100);           // rise and fall overlap
      send_request(24'd200, 24'd105);
      send_request(24'd1000, 24'd3);            // not a multiple of five
      send_request(24'd1000, 24'd500);          // flat middle
      send_request(24'd1000, 24'd50);
      send_request(24'd1000, 24'd95);
      send_request(24'd1000, 24'd900);          // fall begins
      send_request(24'd1000, 24'd1000);         // last step
      send_request(24'd1000, 24'd1005);         // past the end, small
      send_request(24'd1000, 24'd2000);         // past the end, clamps low
      send_request(24'hFFFFFF, 24'hFFFFFF);
      send_request(24'hFFFFFF, 24'd0);
      send_request(24'hFFFFFF, 24'hFFFFFA);
      send_request(24'hFFFFFF, 24'h7FFFFE);
      send_request(24'hAAAAAA, 24'h555555);
      send_request(24'h555555, 24'hAAAAAA);
      req_if.valid <= 1'b0;
      wait_drained();

      // Sender mostly busy, receiver mostly stalled
      run_phase(1'b1, 15'd1, 16'hFFFF, 16'd0, 16'd0, 12, 73);
      run_phase(1'b1, 15'd32767, 16'd0, 16'hFFFF, 16'hFFFF, 12, 73);
      // Sender mostly idle, receiver mostly ready; zero ramp length and ramping off
      run_phase(1'b1, 15'd0, 16'd5000, 16'd20, 16'd7, 73, 12);
      run_phase(1'b0, 15'd50, 16'd2000, 16'd10, 16'd300, 73, 12);
      // No idling; the long receiver hold falls in here
      run_phase(1'b1, 15'($urandom_range(300, 2)), 16'($urandom), 16'($urandom),
                16'($urandom), 0, 0);
      run_phase(1'b1, 15'd7, 16'd300, 16'd300, 16'd1, 0, 0);
      run_phase(1'b1, 15'd5, 16'd40000, 16'd1, 16'd12345, 0, 0);

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.pending() != 0) begin
         board.errors++;
         $display("%0t: %0d expected responses never arrived", $time, board.pending());
      end
      $display("Sent %0d step requests under %0d register settings, incl. ramping off,",
               requests_sent, settings_run);
      $display("zero and maximum ramp lengths; %0d responses checked, %0d with a speed update.",
               board.checked, board.updates);
      if (board.errors == 0)
         $display("tb_stepper_trapezoid_ramp_speed passed");
      else
         $display("tb_stepper_trapezoid_ramp_speed failed");
      $finish;
   end

endmodule
